[hw/rtl/baseline_phasor_channel_generator_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the baseline phasor channel generator
// Shared assertion wrappers used by the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef BASELINE_PHASOR_CHANNEL_GENERATOR_UNIT_DEFINES_SVH
`define BASELINE_PHASOR_CHANNEL_GENERATOR_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define BPCG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BPCG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/bpcg_pkg.sv]
// ---------------------------------------------------------------------------
// Baseline phasor channel generator package
// Widths, codes, command and status types and fixed-point helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package bpcg_pkg;

   localparam int MAX_CHANNELS = 64;
   localparam int CHAN_W       = $clog2(MAX_CHANNELS + 1);
   localparam int CFG_W        = 7;
   localparam int DATA_W       = 32;
   localparam int N_W          = 31;
   localparam int PROD_W       = 2 * DATA_W;
   localparam int SUM_W        = PROD_W + 1;
   localparam int MAG_W        = PROD_W;
   localparam int FRAC_SHIFT   = 30;
   localparam int DIV_PRESHIFT = 6;
   localparam int DIV_W        = MAG_W - DIV_PRESHIFT;
   localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
   localparam int REQ_W        = ((8 * DATA_W + N_W + 7) / 8) * 8;
   localparam int RSP_W        = 2 * DATA_W;

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NUM,
      ST_SUM_NUM,
      ST_FIT_STEP,
      ST_DIVIDE,
      ST_FIT_NUM,
      ST_EMIT,
      ST_MUL_REC,
      ST_FIT_REC
   } state_type;

   typedef enum logic [1:0] {
      MUL_BASE,
      MUL_STEP,
      MUL_REC
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        start_div;
      logic        fit_step;
      logic        fit_num;
      logic        fit_rec;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
   } dp_status_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } fit_type;

   function automatic logic [MAG_W-1:0] magnitude(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] full;
      full = s[SUM_W-1] ? (~s + 1'b1) : s;
      return full[MAG_W-1:0];
   endfunction

   // Applies the sign to a truncated quotient magnitude and clips to 32 bits.
   function automatic fit_type clip_quotient(input logic neg, input logic [DIV_W-1:0] q);
      logic [DIV_W-1:0] pos_lim;
      logic [DIV_W-1:0] neg_lim;
      logic [DIV_W-1:0] lim;
      logic [DIV_W-1:0] clipped;
      logic [DIV_W-1:0] negated;
      fit_type          r;
      pos_lim = {{(DIV_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      neg_lim = pos_lim + 1'b1;
      lim     = neg ? neg_lim : pos_lim;
      r.sat   = (q > lim);
      clipped = r.sat ? lim : q;
      negated = ~clipped + 1'b1;
      r.value = neg ? negated[DATA_W-1:0] : clipped[DATA_W-1:0];
      return r;
   endfunction

   function automatic fit_type fit_shift(input logic [SUM_W-1:0] s);
      logic [MAG_W-1:0] shifted;
      shifted = magnitude(s) >> FRAC_SHIFT;
      return clip_quotient(s[SUM_W-1], shifted[DIV_W-1:0]);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bpcg_divider.sv]
// ---------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bpcg_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [bpcg_pkg::DIV_W-1:0]    dividend,
   input  wire logic [bpcg_pkg::N_W-1:0]      divisor,
   output logic                               busy,
   output logic [bpcg_pkg::DIV_W-1:0]         quotient
);

   logic [bpcg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [bpcg_pkg::N_W-1:0]       rem_ff, rem_in;
   logic [bpcg_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [bpcg_pkg::N_W-1:0]       dvs_ff, dvs_in;
   logic [bpcg_pkg::N_W:0]         trial;
   logic [bpcg_pkg::N_W:0]         diff;
   logic                           ge;

   assign trial = {rem_ff, quo_ff[bpcg_pkg::DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = bpcg_pkg::DIV_CNT_W'(bpcg_pkg::DIV_W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = ge ? diff[bpcg_pkg::N_W-1:0] : trial[bpcg_pkg::N_W-1:0];
         quo_in = {quo_ff[bpcg_pkg::DIV_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[hw/rtl/bpcg_datapath.sv]
// ---------------------------------------------------------------------------
// Phasor datapath
// Input registers, four registered multipliers, sums, clipping, divider
// lanes for the first value, running and step phasors and the clip flag.
// ---------------------------------------------------------------------------
`default_nettype none

module bpcg_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bpcg_pkg::dp_cmd_type          cmd,
   output bpcg_pkg::dp_status_type            status,
   input  wire logic [bpcg_pkg::REQ_W-1:0]    req_tdata,
   output logic [bpcg_pkg::DATA_W-1:0]        value_re,
   output logic [bpcg_pkg::DATA_W-1:0]        value_im,
   output logic                               saturated
);

   localparam int DW = bpcg_pkg::DATA_W;

   logic signed [DW-1:0] l_re_ff, l_im_ff, r_re_ff, r_im_ff;
   logic signed [DW-1:0] dl_re_ff, dl_im_ff, dr_re_ff, dr_im_ff;
   logic [bpcg_pkg::N_W-1:0] n_ff;

   logic signed [DW-1:0] run_re_ff, run_re_in, run_im_ff, run_im_in;
   logic signed [DW-1:0] step_re_ff, step_re_in, step_im_ff, step_im_in;
   logic                 sat_ff, sat_in;
   logic [1:0]           num_neg_ff, num_zero_ff;

   logic signed [DW-1:0] x_re, x_im, y_re, y_im;
   logic signed [bpcg_pkg::PROD_W-1:0] prod_ff [4];
   logic signed [bpcg_pkg::SUM_W-1:0]  p_ext [4];
   logic signed [bpcg_pkg::SUM_W-1:0]  sum_re, sum_im;

   logic [bpcg_pkg::MAG_W-1:0] mag_re, mag_im;
   logic [bpcg_pkg::DIV_W-1:0] quo_re, quo_im;
   logic                       busy_re, busy_im;

   bpcg_pkg::fit_type sh_re, sh_im, dv_re, dv_im;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         l_re_ff  <= req_tdata[0*DW +: DW];
         l_im_ff  <= req_tdata[1*DW +: DW];
         r_re_ff  <= req_tdata[2*DW +: DW];
         r_im_ff  <= req_tdata[3*DW +: DW];
         dl_re_ff <= req_tdata[4*DW +: DW];
         dl_im_ff <= req_tdata[5*DW +: DW];
         dr_re_ff <= req_tdata[6*DW +: DW];
         dr_im_ff <= req_tdata[7*DW +: DW];
         n_ff     <= req_tdata[8*DW +: bpcg_pkg::N_W];
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         bpcg_pkg::MUL_BASE: begin
            x_re = r_re_ff;   x_im = r_im_ff;   y_re = l_re_ff;    y_im = l_im_ff;
         end
         bpcg_pkg::MUL_STEP: begin
            x_re = dr_re_ff;  x_im = dr_im_ff;  y_re = dl_re_ff;   y_im = dl_im_ff;
         end
         bpcg_pkg::MUL_REC: begin
            x_re = run_re_ff; x_im = run_im_ff; y_re = step_re_ff; y_im = step_im_ff;
         end
         default: begin
            x_re = r_re_ff;   x_im = r_im_ff;   y_re = l_re_ff;    y_im = l_im_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff[0] <= x_re * y_re;
      prod_ff[1] <= x_im * y_im;
      prod_ff[2] <= x_im * y_re;
      prod_ff[3] <= x_re * y_im;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p_ext[i] = bpcg_pkg::SUM_W'(prod_ff[i]);
      end
      if (cmd.fit_rec) begin
         sum_re = p_ext[0] - p_ext[1];
         sum_im = p_ext[3] + p_ext[2];
      end else begin
         sum_re = p_ext[0] + p_ext[1];
         sum_im = p_ext[2] - p_ext[3];
      end
   end

   assign mag_re = bpcg_pkg::magnitude(sum_re);
   assign mag_im = bpcg_pkg::magnitude(sum_im);

   bpcg_divider u_div_re (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (mag_re[bpcg_pkg::MAG_W-1:bpcg_pkg::DIV_PRESHIFT]),
      .divisor  (n_ff),
      .busy     (busy_re),
      .quotient (quo_re)
   );

   bpcg_divider u_div_im (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (mag_im[bpcg_pkg::MAG_W-1:bpcg_pkg::DIV_PRESHIFT]),
      .divisor  (n_ff),
      .busy     (busy_im),
      .quotient (quo_im)
   );

   assign status.div_busy = busy_re | busy_im;

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         num_neg_ff  <= {sum_im[bpcg_pkg::SUM_W-1], sum_re[bpcg_pkg::SUM_W-1]};
         num_zero_ff <= {(mag_im == '0), (mag_re == '0)};
      end
   end

   assign sh_re = bpcg_pkg::fit_shift(sum_re);
   assign sh_im = bpcg_pkg::fit_shift(sum_im);

   always_comb begin
      dv_re = bpcg_pkg::clip_quotient(num_neg_ff[0], quo_re);
      dv_im = bpcg_pkg::clip_quotient(num_neg_ff[1], quo_im);
      if (n_ff == '0) begin
         dv_re.sat   = 1'b1;
         dv_im.sat   = 1'b1;
         dv_re.value = num_zero_ff[0] ? '0 :
                       (num_neg_ff[0] ? bpcg_pkg::DATA_MIN : bpcg_pkg::DATA_MAX);
         dv_im.value = num_zero_ff[1] ? '0 :
                       (num_neg_ff[1] ? bpcg_pkg::DATA_MIN : bpcg_pkg::DATA_MAX);
      end
   end

   always_comb begin
      run_re_in  = run_re_ff;
      run_im_in  = run_im_ff;
      step_re_in = step_re_ff;
      step_im_in = step_im_ff;
      sat_in     = sat_ff;
      if (cmd.load) begin
         sat_in = 1'b0;
      end
      if (cmd.fit_step) begin
         step_re_in = sh_re.value;
         step_im_in = sh_im.value;
         sat_in     = sat_ff | sh_re.sat | sh_im.sat;
      end
      if (cmd.fit_num) begin
         run_re_in = dv_re.value;
         run_im_in = dv_im.value;
         sat_in    = sat_ff | dv_re.sat | dv_im.sat;
      end
      if (cmd.fit_rec) begin
         run_re_in = sh_re.value;
         run_im_in = sh_im.value;
         sat_in    = sat_ff | sh_re.sat | sh_im.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
      end else begin
         sat_ff <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      run_re_ff  <= run_re_in;
      run_im_ff  <= run_im_in;
      step_re_ff <= step_re_in;
      step_im_ff <= step_im_in;
   end

   assign value_re  = run_re_ff;
   assign value_im  = run_im_ff;
   assign saturated = sat_ff;

endmodule

`default_nettype wire

[hw/rtl/bpcg_controller.sv]
// ---------------------------------------------------------------------------
// Channel sequencer
// Holds the channel count register, steps one slot through the multiply,
// divide and recurrence phases and drives the stream handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module bpcg_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tlast,
   input  wire logic                          csr_wr_en,
   input  wire logic [bpcg_pkg::CFG_W-1:0]    csr_wr_data,
   output bpcg_pkg::dp_cmd_type               cmd,
   input  wire bpcg_pkg::dp_status_type       status
);

   bpcg_pkg::state_type state_ff, state_in;

   logic [bpcg_pkg::CFG_W-1:0]  num_ch_ff, num_ch_in;
   logic [bpcg_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic [bpcg_pkg::CHAN_W-1:0] chan_next;
   logic [bpcg_pkg::CHAN_W-1:0] nch_eff;

   always_comb begin
      if (num_ch_ff == '0) begin
         nch_eff = bpcg_pkg::CHAN_W'(1);
      end else if (num_ch_ff > bpcg_pkg::CFG_W'(bpcg_pkg::MAX_CHANNELS)) begin
         nch_eff = bpcg_pkg::CHAN_W'(bpcg_pkg::MAX_CHANNELS);
      end else begin
         nch_eff = bpcg_pkg::CHAN_W'(num_ch_ff);
      end
   end

   assign chan_next = chan_ff + 1'b1;
   assign rsp_tlast = (chan_next == nch_eff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpcg_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = bpcg_pkg::ST_MUL_NUM;
         end
         bpcg_pkg::ST_MUL_NUM:  state_in = bpcg_pkg::ST_SUM_NUM;
         bpcg_pkg::ST_SUM_NUM:  state_in = bpcg_pkg::ST_FIT_STEP;
         bpcg_pkg::ST_FIT_STEP: state_in = bpcg_pkg::ST_DIVIDE;
         bpcg_pkg::ST_DIVIDE: begin
            if (!status.div_busy) state_in = bpcg_pkg::ST_FIT_NUM;
         end
         bpcg_pkg::ST_FIT_NUM:  state_in = bpcg_pkg::ST_EMIT;
         bpcg_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               state_in = rsp_tlast ? bpcg_pkg::ST_IDLE : bpcg_pkg::ST_MUL_REC;
            end
         end
         bpcg_pkg::ST_MUL_REC:  state_in = bpcg_pkg::ST_FIT_REC;
         bpcg_pkg::ST_FIT_REC:  state_in = bpcg_pkg::ST_EMIT;
         default:               state_in = bpcg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd.load      = 1'b0;
      cmd.mul_sel   = bpcg_pkg::MUL_BASE;
      cmd.start_div = 1'b0;
      cmd.fit_step  = 1'b0;
      cmd.fit_num   = 1'b0;
      cmd.fit_rec   = 1'b0;
      case (state_ff)
         bpcg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         bpcg_pkg::ST_MUL_NUM: cmd.mul_sel = bpcg_pkg::MUL_BASE;
         bpcg_pkg::ST_SUM_NUM: begin
            cmd.mul_sel   = bpcg_pkg::MUL_STEP;
            cmd.start_div = 1'b1;
         end
         bpcg_pkg::ST_FIT_STEP: cmd.fit_step   = 1'b1;
         bpcg_pkg::ST_FIT_NUM:  cmd.fit_num    = 1'b1;
         bpcg_pkg::ST_EMIT:     rsp_tvalid     = 1'b1;
         bpcg_pkg::ST_MUL_REC:  cmd.mul_sel    = bpcg_pkg::MUL_REC;
         bpcg_pkg::ST_FIT_REC:  cmd.fit_rec    = 1'b1;
         default:               req_tready     = 1'b0;
      endcase
   end

   always_comb begin
      num_ch_in = csr_wr_en ? csr_wr_data : num_ch_ff;
      chan_in   = chan_ff;
      if (state_ff == bpcg_pkg::ST_IDLE && req_tvalid) begin
         chan_in = '0;
      end else if (state_ff == bpcg_pkg::ST_EMIT && rsp_tready && !rsp_tlast) begin
         chan_in = chan_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bpcg_pkg::ST_IDLE;
         num_ch_ff <= bpcg_pkg::CFG_W'(1);
         chan_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         num_ch_ff <= num_ch_in;
         chan_ff   <= chan_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/baseline_phasor_channel_generator_unit.sv]
// ---------------------------------------------------------------------------
// Baseline phasor channel generator
// Emits right*conj(left)/n for the first channel of a time slot, then
// advances it by the step phasor right_step*conj(left_step) per channel.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Beat contents
//  req_     | in        | one time slot: base phasors, step phasors, n term
//  rsp_     | out       | one channel phasor, tlast on the final channel
//  csr_     | in        | num_channels write, no read-back
//
// Most of the wait from a taken beat to the first result is spent in the
// 58-step bit-serial divider for the first value.
// Each further channel passes through emit, multiply, then sum and clip.
// A slot lasts longer with more channels and with output stalls.
// One slot is in work at a time; req_tready is high only while idle.
// Synchronous reset returns to idle and sets num_channels to one.
// ---------------------------------------------------------------------------
`default_nettype none

module baseline_phasor_channel_generator_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // left_re, left_im, right_re, right_im, left_step_re, left_step_im,
   // right_step_re, right_step_im, n_term, one zero pad bit
   input  wire logic [bpcg_pkg::REQ_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // value_re, value_im
   output logic [bpcg_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast,
   // saturated
   output logic                               rsp_tuser,
   input  wire logic                          csr_wr_en,
   input  wire logic [bpcg_pkg::CFG_W-1:0]    csr_wr_data
);

   bpcg_pkg::dp_cmd_type    cmd;
   bpcg_pkg::dp_status_type status;
   logic [bpcg_pkg::DATA_W-1:0] value_re;
   logic [bpcg_pkg::DATA_W-1:0] value_im;

   bpcg_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   bpcg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .value_re  (value_re),
      .value_im  (value_im),
      .saturated (rsp_tuser)
   );

   assign rsp_tdata = {value_im, value_re};

endmodule

`default_nettype wire

[hw/rtl/bpcg_checker.sv]
// ---------------------------------------------------------------------------
// Port checker for the baseline phasor channel generator
// Watches the stream ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "baseline_phasor_channel_generator_unit_defines.svh"

module bpcg_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [bpcg_pkg::RSP_W-1:0]    rsp_tdata,
   input  wire logic                          rsp_tlast,
   input  wire logic                          rsp_tuser
);

   `BPCG_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "Stalled result beat changed.")

   `BPCG_ASSERT(a_no_overlap, !(req_tready && rsp_tvalid), "Input taken while a result is shown.")

   `BPCG_ASSERT(a_busy_after_req, req_tvalid && req_tready |=> !req_tready && !rsp_tvalid, "Block not busy after taking a slot.")

   `BPCG_ASSERT(a_slot_end, rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready, "Block not idle after the last channel.")

   `BPCG_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "Result shown right after reset.")

endmodule

bind baseline_phasor_channel_generator_unit bpcg_checker u_checker (.*);

`default_nettype wire

[tb/baseline_phasor_channel_generator_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Baseline phasor channel generator testbench
// Sends time slots of base and step phasors with an n term and checks every
// channel beat against a fixed-point predictor kept inside this bench.
// Directed slots cover the field extremes, a zero n term and the channel
// count limits. Random slots then run under several channel settings,
// mostly with unit-circle phasors and partly with raw noise. Random idle
// bursts are placed on both streams.
// ---------------------------------------------------------------------------

module baseline_phasor_channel_generator_unit_tb;

   localparam logic [31:0] Q_MAX     = 32'h7fff_ffff;
   localparam logic [31:0] Q_MIN     = 32'h8000_0000;
   localparam logic [31:0] Q_ONE     = 32'h4000_0000;
   localparam logic [31:0] Q_NEG_ONE = 32'hc000_0000;
   localparam logic [31:0] Q_HALF    = 32'h2000_0000;
   localparam int          SLOTS_PER_PHASE = 40;

   typedef struct packed {
      logic        pad;
      logic [30:0] n_term;
      logic [31:0] right_step_im;
      logic [31:0] right_step_re;
      logic [31:0] left_step_im;
      logic [31:0] left_step_re;
      logic [31:0] right_im;
      logic [31:0] right_re;
      logic [31:0] left_im;
      logic [31:0] left_re;
   } slot_type;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        last;
      logic        sat;
   } beat_type;

   typedef struct packed {
      logic [31:0] value;
      logic        hit;
   } clipped_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bpcg_pkg::REQ_W-1:0]     req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bpcg_pkg::RSP_W-1:0]     rsp_tdata;
   logic                           rsp_tlast;
   logic                           rsp_tuser;
   logic                           csr_wr_en = 1'b0;
   logic [bpcg_pkg::CFG_W-1:0]     csr_wr_data = '0;

   beat_type           expected_beats[$];
   int                 mismatch_count = 0;
   int                 stall_left = 0;
   logic               idle_on = 1'b0;
   logic [6:0]         channel_setting = 7'd1;
   logic signed [31:0] run_re = '0;
   logic signed [31:0] run_im = '0;
   logic signed [31:0] step_re = '0;
   logic signed [31:0] step_im = '0;

   baseline_phasor_channel_generator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= int'($urandom_range(0, 11));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic clipped_type scale_clip(input logic signed [65:0] num,
                                              input logic [63:0] divisor);
      logic        neg;
      logic [65:0] mag;
      logic [65:0] q;
      clipped_type r;
      neg   = (num < 0);
      mag   = neg ? -num : num;
      r.hit = 1'b0;
      if (divisor == 0) begin
         r.hit   = 1'b1;
         r.value = (mag == 0) ? 32'd0 : (neg ? Q_MIN : Q_MAX);
         return r;
      end
      q = mag / {2'b00, divisor};
      if (neg) begin
         if (q > 66'h8000_0000) begin
            r.hit = 1'b1;
            q     = 66'h8000_0000;
         end
         r.value = ~q[31:0] + 32'd1;
      end else begin
         if (q > 66'h7fff_ffff) begin
            r.hit = 1'b1;
            q     = 66'h7fff_ffff;
         end
         r.value = q[31:0];
      end
      return r;
   endfunction

   task automatic advance_phasors(input slot_type s);
      logic signed [31:0] lr, li, rr, ri, dlr, dli, drr, dri;
      logic signed [65:0] num_a, num_b;
      logic [63:0]        n_div;
      logic               sat;
      int                 nch;
      clipped_type        a, b;
      beat_type           beat;
      lr  = s.left_re;
      li  = s.left_im;
      rr  = s.right_re;
      ri  = s.right_im;
      dlr = s.left_step_re;
      dli = s.left_step_im;
      drr = s.right_step_re;
      dri = s.right_step_im;
      if (channel_setting == 0) begin
         nch = 1;
      end else if (channel_setting > bpcg_pkg::MAX_CHANNELS) begin
         nch = bpcg_pkg::MAX_CHANNELS;
      end else begin
         nch = int'(channel_setting);
      end
      n_div = {33'd0, s.n_term} << 6;
      num_a = rr * lr + ri * li;
      num_b = ri * lr - rr * li;
      a = scale_clip(num_a, n_div);
      b = scale_clip(num_b, n_div);
      run_re = a.value;
      run_im = b.value;
      sat = a.hit | b.hit;
      num_a = drr * dlr + dri * dli;
      num_b = dri * dlr - drr * dli;
      a = scale_clip(num_a, 64'd1 << 30);
      b = scale_clip(num_b, 64'd1 << 30);
      step_re = a.value;
      step_im = b.value;
      sat = sat | a.hit | b.hit;
      for (int k = 0; k < nch; k++) begin
         if (k > 0) begin
            num_a = run_re * step_re - run_im * step_im;
            num_b = run_re * step_im + run_im * step_re;
            a = scale_clip(num_a, 64'd1 << 30);
            b = scale_clip(num_b, 64'd1 << 30);
            run_re = a.value;
            run_im = b.value;
            sat = sat | a.hit | b.hit;
         end
         beat.re   = run_re;
         beat.im   = run_im;
         beat.last = (k == nch - 1);
         beat.sat  = sat;
         expected_beats.push_back(beat);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : beat_check
      beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual %h last %b sat %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            check_field("value_re", want.re, rsp_tdata[31:0]);
            check_field("value_im", want.im, rsp_tdata[63:32]);
            check_field("last", {31'd0, want.last}, {31'd0, rsp_tlast});
            check_field("saturated", {31'd0, want.sat}, {31'd0, rsp_tuser});
         end
      end
   end

   function automatic slot_type make_slot(input logic [31:0] lr, li, rr, ri,
                                          input logic [31:0] dlr, dli, drr, dri,
                                          input logic [30:0] n);
      slot_type s;
      s = '{1'b0, n, dri, drr, dli, dlr, ri, rr, li, lr};
      return s;
   endfunction

   function automatic logic [31:0] q30(input real x);
      return $rtoi(x * 1073741824.0);
   endfunction

   function automatic logic [63:0] unit_phasor(input real amp);
      real ang;
      ang = $urandom_range(0, 62831) / 10000.0;
      return {q30(amp * $sin(ang)), q30(amp * $cos(ang))};
   endfunction

   function automatic slot_type random_slot();
      slot_type s;
      int       pick;
      real      amp;
      s    = '0;
      pick = $urandom_range(0, 9);
      if (pick < 7 || pick == 9) begin
         amp = $urandom_range(1, 1000) / 1000.0;
         {s.left_im, s.left_re} = unit_phasor(amp);
         amp = $urandom_range(1, 1000) / 1000.0;
         {s.right_im, s.right_re} = unit_phasor(amp);
         {s.left_step_im, s.left_step_re} = unit_phasor(1.0);
         {s.right_step_im, s.right_step_re} = unit_phasor(1.0);
         s.n_term = (pick == 9) ? 31'($urandom_range(0, 3)) :
                                  31'($urandom_range(1 << 24, 1 << 30));
      end else begin
         s.left_re       = $urandom;
         s.left_im       = $urandom;
         s.right_re      = $urandom;
         s.right_im      = $urandom;
         s.left_step_re  = $urandom;
         s.left_step_im  = $urandom;
         s.right_step_re = $urandom;
         s.right_step_im = $urandom;
         s.n_term        = 31'($urandom);
      end
      return s;
   endfunction

   task automatic send_slot(input slot_type s);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_phasors(s);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic set_channels(input logic [6:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      channel_setting = value;
   endtask

   task automatic test_reset_setting();
      idle_on = 1'b1;
      send_slot(make_slot(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 31'h4000_0000));
      send_slot(make_slot(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 31'd1));
      send_slot(make_slot(Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, 31'd0));
      send_slot(make_slot(Q_ONE, 0, Q_NEG_ONE, Q_ONE, 0, Q_ONE, Q_ONE, 0, 31'd0));
      send_slot(make_slot(0, 0, 0, 0, 0, 0, 0, 0, 31'd0));
      send_slot(make_slot(Q_ONE, Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE, 0, Q_ONE, 0,
                          31'h7fff_ffff));
      send_slot(make_slot(Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 31'd1));
      send_slot(make_slot(Q_HALF, Q_NEG_ONE, Q_MAX, Q_HALF, Q_ONE, 0, 0, Q_ONE, 31'd64));
   endtask

   task automatic test_multi_channel();
      set_channels(7'd5);
      send_slot(make_slot(Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, 0, Q_ONE, 31'h4000_0000));
      send_slot(make_slot(Q_ONE, 0, Q_ONE, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 31'h4000_0000));
      send_slot(make_slot(Q_ONE, Q_HALF, Q_NEG_ONE, 0, Q_ONE, 0, Q_HALF, Q_HALF, 31'd0));
      send_slot(make_slot(Q_MAX, 0, Q_MAX, 0, Q_ONE, 0, Q_HALF, 0, 31'h0100_0000));
      send_slot(random_slot());
   endtask

   task automatic test_channel_limits();
      set_channels(7'd0);
      send_slot(make_slot(Q_ONE, 0, 0, Q_ONE, Q_ONE, 0, 0, Q_ONE, 31'h2000_0000));
      set_channels(7'd127);
      send_slot(make_slot(Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, Q_ONE, Q_ONE, 31'h4000_0000));
      set_channels(7'd65);
      send_slot(random_slot());
      set_channels(7'd64);
      send_slot(make_slot(Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, Q_HALF, Q_HALF, 31'h0040_0000));
   endtask

   task automatic test_random_slots();
      logic [6:0] plan[9];
      plan = '{7'd1, 7'd3, 7'd64, 7'd2, 7'd127, 7'd8, 7'd0, 7'd16, 7'd5};
      plan[8] = 7'($urandom_range(1, 12));
      for (int p = 0; p < 9; p++) begin
         set_channels(plan[p]);
         idle_on = (p % 3 != 2) && (p != 8);
         for (int i = 0; i < SLOTS_PER_PHASE; i++) begin
            send_slot(random_slot());
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_setting();
      test_multi_channel();
      test_channel_limits();
      test_random_slots();
      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
